@@ rtl/bto_pkg.sv @@
package bto_pkg;

  // Fixed port widths
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned GENOME_MAX   = 2 * WORD_W;
  localparam int unsigned CUT_W        = 4;
  localparam int unsigned FIT_W        = 9;
  localparam int unsigned RAND_BYTE_W  = 8;
  localparam int unsigned RAND_BLOCKS  = 16;

  // Defaults for the top-level parameters
  localparam int unsigned GENOME_BITS_DEF = 128;
  localparam int unsigned BLOCK_BITS_DEF  = 8;

  // Blocks summed per adder in the first reduction stage
  localparam int unsigned GROUP_BLOCKS = 4;

  // Configuration space
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_MUT_THRESHOLD = 3'd0;
  localparam logic [RAND_BYTE_W-1:0] MUT_THRESHOLD_RST = 8'd3;

endpackage

@@ rtl/bto_trap_score.sv @@
module bto_trap_score #(
  parameter int unsigned BLOCK_BITS = bto_pkg::BLOCK_BITS_DEF
) (
  input  logic [BLOCK_BITS-1:0]                blk_i,
  output logic [$clog2(2*BLOCK_BITS+1)-1:0]    score_o
);

  localparam int unsigned SCORE_W = $clog2(2 * BLOCK_BITS + 1);
  localparam int unsigned ONES_W  = $clog2(BLOCK_BITS + 1);
  localparam logic [SCORE_W-1:0] FULL_SCORE = SCORE_W'(2 * BLOCK_BITS);
  localparam logic [SCORE_W-1:0] BASE_SCORE = SCORE_W'(BLOCK_BITS);

  logic [ONES_W-1:0] ones;

  always_comb begin
    ones = '0;
    for (int j = 0; j < BLOCK_BITS; j++) begin
      ones = ones + ONES_W'(blk_i[j]);
    end
  end

  // all ones is the deceptive peak; otherwise reward zeros
  assign score_o = (&blk_i) ? FULL_SCORE : (BASE_SCORE - SCORE_W'(ones));

endmodule

@@ rtl/block_trap_offspring_evaluator.sv @@
// Block-trap offspring evaluator. Each input word carries two 128-bit parent
// genomes (low and high halves), a split block index and one random byte per
// block; the result word carries the mutated child and its deceptive trap
// fitness. Blocks below the split index come from parent A, the rest from
// parent B; a block whose random byte is below mutation_threshold (APB register
// at byte address 0, reset value 3) is inverted. Blocks 16 and up are never
// mutated, trailing bits past the last whole block are crossed over but not
// mutated or scored, and child bits above GENOME_BITS read as zero. The
// datapath is a four-stage pipeline: crossover and mutation, per-block trap
// scoring, group sums of four blocks, final sum into the output register.
// An accepted word moves through the stage 1, 2 and 3 registers into the
// output register, where out_valid_o rises; one word is accepted every cycle
// while in_stall_o is low; a stall on the output holds the pipeline only
// where it is full, so bubbles are squeezed out before in_stall_o rises. Write
// the threshold only while the pipeline is empty.
module block_trap_offspring_evaluator #(
  parameter int unsigned GENOME_BITS = bto_pkg::GENOME_BITS_DEF,
  parameter int unsigned BLOCK_BITS  = bto_pkg::BLOCK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bto_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bto_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bto_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bto_pkg::WORD_W-1:0]      parent_a_low_i,
  input  logic [bto_pkg::WORD_W-1:0]      parent_a_high_i,
  input  logic [bto_pkg::WORD_W-1:0]      parent_b_low_i,
  input  logic [bto_pkg::WORD_W-1:0]      parent_b_high_i,
  input  logic [bto_pkg::CUT_W-1:0]       split_block_i,
  input  logic [bto_pkg::WORD_W-1:0]      random_low_i,
  input  logic [bto_pkg::WORD_W-1:0]      random_high_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bto_pkg::WORD_W-1:0]      child_low_o,
  output logic [bto_pkg::WORD_W-1:0]      child_high_o,
  output logic [bto_pkg::FIT_W-1:0]       child_fitness_o
);

  import bto_pkg::*;

  localparam int unsigned BLOCK_COUNT = GENOME_BITS / BLOCK_BITS;
  localparam int unsigned SCORE_W     = $clog2(2 * BLOCK_BITS + 1);
  localparam int unsigned NUM_GROUPS  = (BLOCK_COUNT + GROUP_BLOCKS - 1) / GROUP_BLOCKS;

  // ---------------------------------------------------------------------
  // Configuration register (decoded on the word address)
  // ---------------------------------------------------------------------
  logic [RAND_BYTE_W-1:0] mut_thr_q, mut_thr_d;
  logic                   cfg_hit;
  logic                   cfg_wr;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_ADDR_W-1:2] == ADDR_MUT_THRESHOLD[APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

  always_comb begin
    mut_thr_d = mut_thr_q;
    if (cfg_wr) begin
      mut_thr_d = pwdata[RAND_BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mut_thr_q <= MUT_THRESHOLD_RST;
    end else begin
      mut_thr_q <= mut_thr_d;
    end
  end

  assign prdata = cfg_hit ? APB_DATA_W'(mut_thr_q) : '0;

  // ---------------------------------------------------------------------
  // Pipeline control: a stage takes new data when it is empty or its
  // occupant moves on this cycle.
  // ---------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s3_ready  = !s3_valid_q || out_ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;

  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (s3_ready)  s3_valid_q  <= s2_valid_q;
      if (out_ready) out_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: block crossover and block mutation
  // ---------------------------------------------------------------------
  logic [GENOME_MAX-1:0]  par_a, par_b, rnd;
  logic [GENOME_BITS-1:0] from_a, flip_mask, child_d;
  logic [GENOME_BITS-1:0] s1_child_q;

  assign par_a = {parent_a_high_i, parent_a_low_i};
  assign par_b = {parent_b_high_i, parent_b_low_i};
  assign rnd   = {random_high_i, random_low_i};

  always_comb begin
    // bit i comes from parent A when its block index is below the split;
    // trailing bits share the index of the next (partial) block
    for (int i = 0; i < GENOME_BITS; i++) begin
      from_a[i] = (int'(split_block_i) > (i / BLOCK_BITS));
    end
    // blocks past the last random byte are never inverted
    flip_mask = '0;
    for (int b = 0; b < BLOCK_COUNT && b < RAND_BLOCKS; b++) begin
      flip_mask[b*BLOCK_BITS +: BLOCK_BITS] =
        {BLOCK_BITS{rnd[b*RAND_BYTE_W +: RAND_BYTE_W] < mut_thr_q}};
    end
    child_d = ((par_a[GENOME_BITS-1:0] & from_a) | (par_b[GENOME_BITS-1:0] & ~from_a))
              ^ flip_mask;
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_child_q <= child_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: per-block trap score
  // ---------------------------------------------------------------------
  logic [SCORE_W-1:0]     blk_score [BLOCK_COUNT];
  logic [SCORE_W-1:0]     s2_score_q [BLOCK_COUNT];
  logic [GENOME_BITS-1:0] s2_child_q;

  for (genvar gb = 0; gb < BLOCK_COUNT; gb++) begin : g_score
    bto_trap_score #(
      .BLOCK_BITS (BLOCK_BITS)
    ) u_score (
      .blk_i   (s1_child_q[gb*BLOCK_BITS +: BLOCK_BITS]),
      .score_o (blk_score[gb])
    );
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_child_q <= s1_child_q;
      s2_score_q <= blk_score;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: partial sums over groups of blocks
  // ---------------------------------------------------------------------
  logic [FIT_W-1:0]       grp_sum [NUM_GROUPS];
  logic [FIT_W-1:0]       s3_sum_q [NUM_GROUPS];
  logic [GENOME_BITS-1:0] s3_child_q;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_sum[g] = '0;
      for (int k = 0; k < GROUP_BLOCKS; k++) begin
        if (g * GROUP_BLOCKS + k < BLOCK_COUNT) begin
          grp_sum[g] = grp_sum[g] + FIT_W'(s2_score_q[g*GROUP_BLOCKS + k]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_child_q <= s2_child_q;
      s3_sum_q   <= grp_sum;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: final sum into the output register
  // ---------------------------------------------------------------------
  logic [FIT_W-1:0]      fit_sum;
  logic [GENOME_MAX-1:0] child_pad;
  logic [GENOME_MAX-1:0] out_child_q;
  logic [FIT_W-1:0]      out_fit_q;

  always_comb begin
    fit_sum = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      fit_sum = fit_sum + s3_sum_q[g];
    end
    // bits above the genome read as zero
    child_pad = '0;
    child_pad[GENOME_BITS-1:0] = s3_child_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s3_valid_q) begin
      out_child_q <= child_pad;
      out_fit_q   <= fit_sum;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign child_low_o     = out_child_q[WORD_W-1:0];
  assign child_high_o    = out_child_q[GENOME_MAX-1:WORD_W];
  assign child_fitness_o = out_fit_q;

endmodule

@@ rtl/bto_checker.sv @@
module bto_checker #(
  parameter int unsigned GENOME_BITS = bto_pkg::GENOME_BITS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [bto_pkg::APB_ADDR_W-1:0]  paddr,
  input logic [bto_pkg::APB_DATA_W-1:0]  pwdata,
  input logic [bto_pkg::APB_DATA_W-1:0]  prdata,
  input logic                            pready,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [bto_pkg::WORD_W-1:0]      child_low_o,
  input logic [bto_pkg::WORD_W-1:0]      child_high_o,
  input logic [bto_pkg::FIT_W-1:0]       child_fitness_o
);

  import bto_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(child_low_o)
      && $stable(child_high_o) && $stable(child_fitness_o))
    else $error("stalled result word changed");

  // fitness never exceeds twice the genome length
  a_fit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(child_fitness_o) <= 2 * GENOME_BITS))
    else $error("fitness out of range");

  // with the output left free, an accepted word reaches out_valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("result word missing after pipeline latency");

  // threshold write reads back
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr == ADDR_MUT_THRESHOLD)
      |=> (paddr != ADDR_MUT_THRESHOLD)
          || (prdata[RAND_BYTE_W-1:0] == $past(pwdata[RAND_BYTE_W-1:0])))
    else $error("threshold readback mismatch");

endmodule

bind block_trap_offspring_evaluator bto_checker #(
  .GENOME_BITS (GENOME_BITS)
) u_bto_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr),
  .pwdata          (pwdata),
  .prdata          (prdata),
  .pready          (pready),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .child_low_o     (child_low_o),
  .child_high_o    (child_high_o),
  .child_fitness_o (child_fitness_o)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import bto_pkg::*;

  // Block geometry as instantiated (package defaults)
  localparam int unsigned GENOME = GENOME_BITS_DEF;
  localparam int unsigned BLK    = BLOCK_BITS_DEF;
  localparam int unsigned NBLK   = GENOME / BLK;

  localparam int unsigned PHASE_WORDS     = 280;  // random words per threshold setting
  localparam int unsigned NUM_PHASES      = 7;
  localparam int unsigned QUIET_PHASE     = 3;    // no idling on either side
  localparam int unsigned HOLD_OFF_AFTER  = 400;  // words accepted before the long hold-off
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned TAIL_CYCLES     = 8;    // pipeline is four deep

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] ALL_ZERO = '0;

  // one input word: two parents, cut point, random bytes
  typedef struct packed {
    logic [WORD_W-1:0] a_lo;
    logic [WORD_W-1:0] a_hi;
    logic [WORD_W-1:0] b_lo;
    logic [WORD_W-1:0] b_hi;
    logic [CUT_W-1:0]  cut;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W-1:0] r_hi;
  } parents_word_t;

  // one result word: child genome and its trap fitness
  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [FIT_W-1:0]  fitness;
  } child_word_t;

  // Predicts each child at input acceptance and checks results in order.
  class offspring_scoreboard;
    child_word_t            expected_children[$];
    logic [RAND_BYTE_W-1:0] threshold;
    int unsigned            words_in;
    int unsigned            children_checked;
    int unsigned            mismatches;

    function new();
      threshold        = MUT_THRESHOLD_RST;
      words_in         = 0;
      children_checked = 0;
      mismatches       = 0;
    endfunction

    // crossover at the block cut, block-wise inversion, then trap scoring
    function child_word_t breed(parents_word_t w);
      logic [GENOME_MAX-1:0] pa;
      logic [GENOME_MAX-1:0] pb;
      logic [GENOME_MAX-1:0] rnd;
      logic [GENOME_MAX-1:0] child;
      logic [BLK-1:0]        blk;
      int unsigned           ones;
      int unsigned           fit;
      child_word_t           c;
      pa    = {w.a_hi, w.a_lo};
      pb    = {w.b_hi, w.b_lo};
      rnd   = {w.r_hi, w.r_lo};
      child = '0;
      fit   = 0;
      for (int i = 0; i < GENOME; i++)
        child[i] = (i < w.cut * BLK) ? pa[i] : pb[i];
      for (int k = 0; k < NBLK; k++) begin
        blk = child[k*BLK +: BLK];
        // only the first RAND_BLOCKS blocks own a random byte
        if (k < RAND_BLOCKS && rnd[k*RAND_BYTE_W +: RAND_BYTE_W] < threshold)
          blk = ~blk;
        child[k*BLK +: BLK] = blk;
        ones = $countones(blk);
        fit += (ones == BLK) ? 2 * BLK : BLK - ones;
      end
      c.lo      = child[WORD_W-1:0];
      c.hi      = child[GENOME_MAX-1:WORD_W];
      c.fitness = fit[FIT_W-1:0];
      return c;
    endfunction

    function void note_parents(parents_word_t w);
      expected_children = {expected_children, breed(w)};
      words_in++;
    endfunction

    function void flag(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] seen);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, seen);
    endfunction

    function void check_child(child_word_t got);
      child_word_t want;
      if (expected_children.size() == 0) begin
        flag("child word with nothing pending", ALL_ZERO, got.lo);
        return;
      end
      want = expected_children[0];
      expected_children.delete(0);
      children_checked++;
      if (got.lo !== want.lo)           flag("child_low", want.lo, got.lo);
      if (got.hi !== want.hi)           flag("child_high", want.hi, got.hi);
      if (got.fitness !== want.fitness) flag("child_fitness", want.fitness, got.fitness);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic              in_valid_i;
  logic              in_stall_o;
  logic [WORD_W-1:0] parent_a_low_i;
  logic [WORD_W-1:0] parent_a_high_i;
  logic [WORD_W-1:0] parent_b_low_i;
  logic [WORD_W-1:0] parent_b_high_i;
  logic [CUT_W-1:0]  split_block_i;
  logic [WORD_W-1:0] random_low_i;
  logic [WORD_W-1:0] random_high_i;

  logic              out_valid_o;
  logic              out_stall_i;
  logic [WORD_W-1:0] child_low_o;
  logic [WORD_W-1:0] child_high_o;
  logic [FIT_W-1:0]  child_fitness_o;

  offspring_scoreboard sb;

  bit no_idle      = 1'b0;  // set for the quiet phase
  bit holding_off  = 1'b0;  // receiver is in its long hold-off
  bit hold_off_done = 1'b0;

  block_trap_offspring_evaluator dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // parent block: biased towards all-ones, all-zeros and near-trap patterns
  function automatic logic [BLK-1:0] random_block();
    logic [BLK-1:0] b;
    logic [BLK-1:0] one_hot;
    b       = BLK'($urandom);
    one_hot = '0;
    one_hot[$urandom_range(0, BLK - 1)] = 1'b1;
    case ($urandom_range(0, 9))
      5, 6:    b = '1;
      7:       b = '0;
      8:       b = ~one_hot;
      9:       b = one_hot;
      default: ;
    endcase
    return b;
  endfunction

  // random byte: clustered around the threshold edge and the byte extremes
  function automatic logic [RAND_BYTE_W-1:0] random_draw(logic [RAND_BYTE_W-1:0] thr);
    logic [RAND_BYTE_W-1:0] d;
    d = RAND_BYTE_W'($urandom);
    case ($urandom_range(0, 7))
      4:       d = thr - 8'd1;
      5:       d = thr;
      6:       d = '0;
      7:       d = '1;
      default: ;
    endcase
    return d;
  endfunction

  function automatic parents_word_t random_word(logic [RAND_BYTE_W-1:0] thr);
    logic [GENOME_MAX-1:0] pa;
    logic [GENOME_MAX-1:0] pb;
    logic [GENOME_MAX-1:0] rnd;
    parents_word_t         w;
    for (int k = 0; k < GENOME_MAX / BLK; k++) begin
      pa[k*BLK +: BLK] = random_block();
      pb[k*BLK +: BLK] = random_block();
    end
    for (int k = 0; k < RAND_BLOCKS; k++)
      rnd[k*RAND_BYTE_W +: RAND_BYTE_W] = random_draw(thr);
    w.a_lo = pa[WORD_W-1:0];
    w.a_hi = pa[GENOME_MAX-1:WORD_W];
    w.b_lo = pb[WORD_W-1:0];
    w.b_hi = pb[GENOME_MAX-1:WORD_W];
    w.r_lo = rnd[WORD_W-1:0];
    w.r_hi = rnd[GENOME_MAX-1:WORD_W];
    w.cut  = CUT_W'($urandom_range(0, 15));
    return w;
  endfunction

  // Offer one word, hold it until accepted, then maybe idle.
  // Stall is sampled on the falling edge, where it is settled for the next rise.
  task automatic send_word(parents_word_t w);
    logic        stalled;
    int unsigned gap;
    in_valid_i      <= 1'b1;
    parent_a_low_i  <= w.a_lo;
    parent_a_high_i <= w.a_hi;
    parent_b_low_i  <= w.b_lo;
    parent_b_high_i <= w.b_hi;
    split_block_i   <= w.cut;
    random_low_i    <= w.r_lo;
    random_high_i   <= w.r_hi;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    sb.note_parents(w);
    // keep offering during the hold-off so the pipeline backs up
    gap = (no_idle || holding_off) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_children_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_children.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_wait_ready(output logic [APB_DATA_W-1:0] rdata);
    logic rdy;
    do begin
      @(negedge clk_i);
      rdy   = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // write then read back the threshold as two back-to-back transfers
  task automatic configure_threshold(logic [RAND_BYTE_W-1:0] thr);
    logic [APB_DATA_W-1:0] rdata;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MUT_THRESHOLD;
    pwdata  <= APB_DATA_W'(thr);
    @(posedge clk_i);
    penable <= 1'b1;
    apb_wait_ready(rdata);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    apb_wait_ready(rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.threshold = thr;
    if (rdata !== APB_DATA_W'(thr))
      sb.flag("threshold readback", WORD_W'(thr), WORD_W'(rdata));
  endtask

  // Directed words under the reset threshold of 3: field extremes, both cut
  // extremes, all-ones trap blocks, random bytes either side of the threshold,
  // then a sweep over every cut value.
  task automatic run_directed();
    parents_word_t w;
    send_word('{ALL_ZERO, ALL_ZERO, ALL_ZERO, ALL_ZERO, 4'd0, ALL_ONES, ALL_ONES});
    send_word('{ALL_ONES, ALL_ONES, ALL_ZERO, ALL_ZERO, 4'd15, ALL_ONES, ALL_ONES});
    send_word('{ALL_ZERO, ALL_ZERO, ALL_ONES, ALL_ONES, 4'd0, ALL_ONES, ALL_ONES});
    send_word('{ALL_ONES, ALL_ONES, ALL_ZERO, ALL_ZERO, 4'd1, ALL_ONES, ALL_ONES});
    // every block inverted
    send_word('{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 4'd7, ALL_ZERO, ALL_ZERO});
    send_word('{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8,
                64'h0203_0405_0203_0102, 64'h0302_0100_FF03_0203});
    send_word('{64'hFEFE_FEFE_FEFE_FEFE, 64'h7F7F_7F7F_7F7F_7F7F,
                64'h0101_0101_0101_0101, 64'h8080_8080_8080_8080, 4'd4,
                ALL_ONES, ALL_ONES});
    send_word('{ALL_ONES, ALL_ZERO, ALL_ZERO, ALL_ONES, 4'd12,
                64'hFF02_FF02_FF02_FF02, 64'h02FF_02FF_02FF_02FF});
    for (int c = 0; c < 16; c++) begin
      w     = random_word(sb.threshold);
      w.cut = CUT_W'(c);
      send_word(w);
    end
  endtask

  // Receiver: random stall pattern, plus one long hold-off once enough
  // words have gone in. One stall assignment per clock.
  initial begin
    int unsigned stall_left;
    int unsigned ready_left;
    int unsigned hold_left;
    logic        stall;
    stall_left  = 0;
    ready_left  = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (!hold_off_done && sb.words_in >= HOLD_OFF_AFTER) begin
        hold_left     = HOLD_OFF_CYCLES - 1;
        hold_off_done = 1'b1;
        stall         = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else if (ready_left > 0) begin
        ready_left--;
        stall = 1'b0;
      end else begin
        ready_left = $urandom_range(0, 15);
        stall_left = no_idle ? 0 : pick_gap();
        stall      = 1'b0;
      end
      holding_off = (hold_left > 0);
      out_stall_i <= stall;
    end
  end

  // Result monitor: handshake sampled on the falling edge, checked at the rise.
  initial begin
    child_word_t got;
    logic        take;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      take = out_valid_o && !out_stall_i;
      got  = '{child_low_o, child_high_o, child_fitness_o};
      @(posedge clk_i);
      if (take) sb.check_child(got);
    end
  end

  // Main sequence: directed words, then one phase of random words per threshold.
  initial begin
    logic [RAND_BYTE_W-1:0] phase_thr [NUM_PHASES];
    logic [RAND_BYTE_W-1:0] thr;
    sb              = new();
    phase_thr       = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd3, 8'd0};
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    parent_a_low_i  = '0;
    parent_a_high_i = '0;
    parent_b_low_i  = '0;
    parent_b_high_i = '0;
    split_block_i   = '0;
    random_low_i    = '0;
    random_high_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    wait_children_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // two phases draw an arbitrary threshold
      thr = (p == 4 || p == 6) ? 8'($urandom_range(0, 255)) : phase_thr[p];
      configure_threshold(thr);
      no_idle = (p == QUIET_PHASE);
      for (int n = 0; n < PHASE_WORDS; n++)
        send_word(random_word(thr));
      wait_children_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run covered %0d parent words, %0d children checked, %0d threshold settings",
             sb.words_in, sb.children_checked, NUM_PHASES + 1);
    $display("(thresholds 0, 1, 3, 128, 255 and random; every cut value; one long output hold-off)");
    if (sb.mismatches == 0 && sb.expected_children.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
